// ===== src/tps_pkg.sv =====
// Shared types and constants for the three-level priority thread scheduler.
package tps_pkg;

    localparam int DEF_THREAD_SLOTS = 4;
    localparam int NUM_PRIO         = 3;

    localparam logic [1:0] PRIO_LOW = 2'd2;

    localparam logic [2:0] FN_CREATE = 3'd0;
    localparam logic [2:0] FN_YIELD  = 3'd1;
    localparam logic [2:0] FN_EXIT   = 3'd2;
    localparam logic [2:0] FN_START  = 3'd3;
    localparam logic [2:0] FN_SETPRI = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_FULL        = 3'd1,
        STAT_STARTED     = 3'd2,
        STAT_NOT_STARTED = 3'd3,
        STAT_HALTED      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SS_FREE     = 2'd0,
        SS_RUNNABLE = 2'd1,
        SS_RUNNING  = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } rq_ctrl_t;

endpackage

// ===== src/tps_if.sv =====
// Valid/ready channel interfaces for scheduler command and response words.
interface tps_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [1:0] priority_req;

    modport source (output valid, output func, output priority_req, input ready);
    modport sink   (input valid, input func, input priority_req, output ready);
endinterface

interface tps_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       running_valid;
    logic [1:0] running_slot;
    logic [1:0] running_priority;
    logic [1:0] previous_priority;
    logic [1:0] created_slot;

    modport source (output valid, output status, output running_valid, output running_slot,
                    output running_priority, output previous_priority, output created_slot,
                    input ready);
    modport sink   (input valid, input status, input running_valid, input running_slot,
                    input running_priority, input previous_priority, input created_slot,
                    output ready);
endinterface

// ===== src/tps_rdyq.sv =====
// Shift-register ready queue for one priority level with same-cycle push and pop.
module tps_rdyq
    import tps_pkg::*;
#(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rq_ctrl_t                              ctrl,
    input  logic [$clog2(THREAD_SLOTS)-1:0]       push_slot,
    output logic                                  nonempty_mid,
    output logic [$clog2(THREAD_SLOTS)-1:0]       head_mid
);

    localparam int SW = $clog2(THREAD_SLOTS);
    localparam int CW = $clog2(THREAD_SLOTS + 1);

    logic [SW-1:0] entries_reg  [THREAD_SLOTS];
    logic [SW-1:0] entries_next [THREAD_SLOTS];
    logic [SW-1:0] mid          [THREAD_SLOTS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cnt_mid;
    logic          push_ok;

    always_comb
    begin
        push_ok = ctrl.push && (count_reg < CW'(THREAD_SLOTS));
        for (int i = 0; i < THREAD_SLOTS; i++)
        begin
            mid[i] = (push_ok && count_reg == CW'(i)) ? push_slot : entries_reg[i];
        end
        cnt_mid      = count_reg + CW'(push_ok);
        nonempty_mid = (cnt_mid != '0);
        head_mid     = mid[0];
        if (ctrl.pop)
        begin
            for (int i = 0; i < THREAD_SLOTS - 1; i++)
            begin
                entries_next[i] = mid[i + 1];
            end
            entries_next[THREAD_SLOTS-1] = mid[THREAD_SLOTS-1];
            count_next = cnt_mid - CW'(1);
        end
        else
        begin
            entries_next = mid;
            count_next   = cnt_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> nonempty_mid)
        else $error("pop from empty ready queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(THREAD_SLOTS))
        else $error("ready queue count exceeds slot count");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.pop && !ctrl.push) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("ready queue count did not drop on pop");

endmodule

// ===== src/three_level_priority_thread_scheduler.sv =====
// Top level of the three-level strict-priority thread scheduler.
// Latency: a command word accepted at one edge has its response word valid after that edge.
// Throughput: one word per cycle unless rsp.ready stalls; the single response register refills as it drains.
// The per-word path is a free-slot find-first and three ready-queue updates.
// Reset: all slots free, queues empty, not started, not halted, no response pending.
module three_level_priority_thread_scheduler
    import tps_pkg::*;
#(
    parameter int THREAD_SLOTS = DEF_THREAD_SLOTS
)
(
    input  logic          clk,
    input  logic          rst_n,
    tps_cmd_if.sink       cmd,
    tps_rsp_if.source     rsp
);

    localparam int SW = $clog2(THREAD_SLOTS);

    slot_state_t   state_reg [THREAD_SLOTS];
    slot_state_t   state_next [THREAD_SLOTS];
    logic [1:0]    prio_reg  [THREAD_SLOTS];
    logic [1:0]    prio_next [THREAD_SLOTS];
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] cur_next;
    logic          started_reg;
    logic          started_next;
    logic          halted_reg;
    logic          halted_next;

    logic          out_valid_reg;
    status_t       status_reg;
    logic          run_valid_reg;
    logic [1:0]    run_slot_reg;
    logic [1:0]    run_prio_reg;
    logic [1:0]    prev_prio_reg;
    logic [1:0]    created_reg;

    logic          accept;
    logic [1:0]    prio_sat;
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic          live;
    logic          do_create;
    logic          do_start;
    logic          do_yield;
    logic          do_exit;
    logic          do_set;
    logic          dispatch;
    logic          halt_set;
    logic [1:0]    cur_prio;
    logic [SW-1:0] push_slot;
    rq_ctrl_t      q_ctrl [NUM_PRIO];
    logic          q_ne   [NUM_PRIO];
    logic [SW-1:0] q_head [NUM_PRIO];
    logic          higher_ne;
    logic [SW-1:0] sel_slot;
    status_t       status_c;
    logic          running_c;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign prio_sat  = (cmd.priority_req > PRIO_LOW) ? PRIO_LOW : cmd.priority_req;
    assign cur_prio  = prio_reg[cur_reg];

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (state_reg[i] == SS_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign live      = accept && !halted_reg;
    assign do_create = live && cmd.func == FN_CREATE && free_found;
    assign do_start  = live && cmd.func == FN_START && !started_reg;
    assign do_yield  = live && started_reg && cmd.func == FN_YIELD;
    assign do_exit   = live && started_reg && cmd.func == FN_EXIT;
    assign do_set    = live && started_reg && cmd.func == FN_SETPRI;
    assign dispatch  = do_start || do_yield || do_exit;
    assign push_slot = do_create ? free_idx : cur_reg;

    always_comb
    begin
        higher_ne = 1'b0;
        sel_slot  = '0;
        for (int q = 0; q < NUM_PRIO; q++)
        begin
            q_ctrl[q].push = (do_create && prio_sat == 2'(q)) || (do_yield && cur_prio == 2'(q));
            q_ctrl[q].pop  = dispatch && q_ne[q] && !higher_ne;
            if (q_ne[q] && !higher_ne)
            begin
                sel_slot = q_head[q];
            end
            higher_ne = higher_ne || q_ne[q];
        end
        halt_set = dispatch && !higher_ne;
    end

    for (genvar q = 0; q < NUM_PRIO; q++)
    begin : g_rq
        tps_rdyq #(
            .THREAD_SLOTS (THREAD_SLOTS)
        ) u_rdyq (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (q_ctrl[q]),
            .push_slot    (push_slot),
            .nonempty_mid (q_ne[q]),
            .head_mid     (q_head[q])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        prio_next    = prio_reg;
        cur_next     = cur_reg;
        started_next = started_reg || do_start;
        halted_next  = halted_reg || halt_set;
        if (do_create)
        begin
            state_next[free_idx] = SS_RUNNABLE;
            prio_next[free_idx]  = prio_sat;
        end
        if (do_yield)
        begin
            state_next[cur_reg] = SS_RUNNABLE;
        end
        if (do_exit)
        begin
            state_next[cur_reg] = SS_FREE;
        end
        if (do_set)
        begin
            prio_next[cur_reg] = prio_sat;
        end
        if (dispatch && !halt_set)
        begin
            cur_next             = sel_slot;
            state_next[sel_slot] = SS_RUNNING;
        end
    end

    always_comb
    begin
        if (halted_reg || halt_set)
            status_c = STAT_HALTED;
        else if (cmd.func == FN_CREATE && !free_found)
            status_c = STAT_FULL;
        else if (cmd.func == FN_START && started_reg)
            status_c = STAT_STARTED;
        else if (!started_reg && (cmd.func == FN_YIELD || cmd.func == FN_EXIT
                                  || cmd.func == FN_SETPRI))
            status_c = STAT_NOT_STARTED;
        else
            status_c = STAT_OK;
        running_c = started_next && !halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                state_reg[i] <= SS_FREE;
            end
            cur_reg       <= '0;
            started_reg   <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            started_reg <= started_next;
            halted_reg  <= halted_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        if (accept)
        begin
            status_reg    <= status_c;
            run_valid_reg <= running_c;
            run_slot_reg  <= running_c ? 2'(cur_next) : 2'd0;
            run_prio_reg  <= running_c ? prio_next[cur_next] : 2'd0;
            prev_prio_reg <= do_set ? cur_prio : 2'd0;
            created_reg   <= do_create ? 2'(free_idx) : 2'd0;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.running_valid     = run_valid_reg;
    assign rsp.running_slot      = run_slot_reg;
    assign rsp.running_priority  = run_prio_reg;
    assign rsp.previous_priority = prev_prio_reg;
    assign rsp.created_slot      = created_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg && !halted_reg) |-> state_reg[cur_reg] == SS_RUNNING)
        else $error("current slot not marked running");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no response");

    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg) |=> status_reg == STAT_HALTED && !run_valid_reg)
        else $error("halted block returned wrong response");

endmodule

// ===== tb/three_level_priority_thread_scheduler_tb.sv =====
// Self-checking testbench for the three-level priority thread scheduler.
`timescale 1ns / 1ps

module three_level_priority_thread_scheduler_tb
    import tps_pkg::*;
();

    localparam int SLOTS = DEF_THREAD_SLOTS;
    localparam logic [2:0] FN_RSVD_LO = 3'd5;
    localparam logic [2:0] FN_RSVD_HI = 3'd7;
    localparam int RANDOM_WORDS = 1900;

    typedef struct packed {
        status_t    status;
        logic       running_valid;
        logic [1:0] running_slot;
        logic [1:0] running_priority;
        logic [1:0] previous_priority;
        logic [1:0] created_slot;
    } reply_t;

    class thread_table_tracker;
        slot_state_t slot_st [SLOTS];
        logic [1:0]  slot_pri [SLOTS];
        logic [1:0]  rq_entry [NUM_PRIO][SLOTS];
        int          rq_head [NUM_PRIO];
        int          rq_count [NUM_PRIO];
        logic [1:0]  cur;
        bit          started;
        bit          halted;
        reply_t      expected_replies [$];
        int          mismatches;

        function new();
            foreach (slot_st[i])
            begin
                slot_st[i]  = SS_FREE;
                slot_pri[i] = 2'd0;
            end
            foreach (rq_head[q])
            begin
                rq_head[q]  = 0;
                rq_count[q] = 0;
            end
            cur        = 2'd0;
            started    = 1'b0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function bit exit_halts();
            return started && !halted && rq_count[0] == 0 && rq_count[1] == 0 && rq_count[2] == 0;
        endfunction

        function void enqueue(logic [1:0] q, logic [1:0] slot);
            if (rq_count[q] < SLOTS)
            begin
                rq_entry[q][(rq_head[q] + rq_count[q]) % SLOTS] = slot;
                rq_count[q]++;
            end
        endfunction

        function void dispatch();
            for (int q = 0; q < NUM_PRIO; q++)
            begin
                if (rq_count[q] != 0)
                begin
                    cur = rq_entry[q][rq_head[q]];
                    rq_head[q] = (rq_head[q] + 1) % SLOTS;
                    rq_count[q]--;
                    slot_st[cur] = SS_RUNNING;
                    return;
                end
            end
            halted = 1'b1;
        endfunction

        function void note_command(logic [2:0] f, logic [1:0] p);
            reply_t     r;
            logic [1:0] pr;
            int         s;
            r = '0;
            r.status = STAT_OK;
            pr = (p > PRIO_LOW) ? PRIO_LOW : p;
            if (halted)
                r.status = STAT_HALTED;
            else if (f == FN_CREATE)
            begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_st[i] == SS_FREE)
                        s = i;
                if (s < 0)
                    r.status = STAT_FULL;
                else
                begin
                    slot_pri[s] = pr;
                    slot_st[s] = SS_RUNNABLE;
                    enqueue(pr, s[1:0]);
                    r.created_slot = s[1:0];
                end
            end
            else if (f == FN_START)
            begin
                if (started)
                    r.status = STAT_STARTED;
                else
                begin
                    started = 1'b1;
                    dispatch();
                end
            end
            else if (f == FN_YIELD || f == FN_EXIT || f == FN_SETPRI)
            begin
                if (!started)
                    r.status = STAT_NOT_STARTED;
                else if (f == FN_YIELD)
                begin
                    slot_st[cur] = SS_RUNNABLE;
                    enqueue(slot_pri[cur], cur);
                    dispatch();
                end
                else if (f == FN_EXIT)
                begin
                    slot_st[cur] = SS_FREE;
                    dispatch();
                end
                else
                begin
                    r.previous_priority = slot_pri[cur];
                    slot_pri[cur] = pr;
                end
            end
            if (halted)
                r.status = STAT_HALTED;
            if (started && !halted)
            begin
                r.running_valid    = 1'b1;
                r.running_slot     = cur;
                r.running_priority = slot_pri[cur];
            end
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t exp_r;
            if (expected_replies.size() == 0)
            begin
                $display("%0t unexpected reply expected none actual status %0d",
                         $time, got.status);
                mismatches++;
                return;
            end
            exp_r = expected_replies.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("running_valid", exp_r.running_valid, got.running_valid);
            compare_field("running_slot", exp_r.running_slot, got.running_slot);
            compare_field("running_priority", exp_r.running_priority, got.running_priority);
            compare_field("previous_priority", exp_r.previous_priority, got.previous_priority);
            compare_field("created_slot", exp_r.created_slot, got.created_slot);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   words_sent;

    tps_cmd_if cmd_ch ();
    tps_rsp_if rsp_ch ();

    thread_table_tracker tracker = new();

    three_level_priority_thread_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FN_CREATE;
        cmd_ch.priority_req = 2'd0;
        rsp_ch.ready = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int pick_gap(bit calm);
        int k;
        if (calm)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 85)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_command(input logic [2:0] f, input logic [1:0] p);
        int gap;
        gap = pick_gap((words_sent / 128) % 4 == 3);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= f;
        cmd_ch.priority_req <= p;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        tracker.note_command(f, p);
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_reply('{status: status_t'(rsp_ch.status),
                                  running_valid: rsp_ch.running_valid,
                                  running_slot: rsp_ch.running_slot,
                                  running_priority: rsp_ch.running_priority,
                                  previous_priority: rsp_ch.previous_priority,
                                  created_slot: rsp_ch.created_slot});
    end

    initial
    begin
        int stall;
        int open_len;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                stall = 0;
                open_len = $urandom_range(60, 200);
            end
            else
            begin
                stall = pick_gap(1'b0);
                open_len = $urandom_range(1, 6);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat (open_len) @(posedge clk);
        end
    end

    initial
    begin
        logic [2:0] f;
        int         k;
        words_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(FN_YIELD, 2'd0);
        send_command(FN_EXIT, 2'd1);
        send_command(FN_SETPRI, 2'd2);
        send_command(FN_RSVD_LO, 2'd3);
        send_command(FN_RSVD_HI, 2'd0);
        send_command(FN_CREATE, 2'd0);
        send_command(FN_CREATE, 2'd3);
        send_command(FN_CREATE, 2'd1);
        send_command(FN_CREATE, 2'd2);
        send_command(FN_CREATE, 2'd0);
        send_command(FN_START, 2'd0);
        send_command(FN_START, 2'd1);
        send_command(FN_CREATE, 2'd1);
        send_command(FN_SETPRI, 2'd3);
        send_command(FN_YIELD, 2'd0);
        send_command(FN_SETPRI, 2'd0);
        send_command(FN_YIELD, 2'd2);
        send_command(FN_EXIT, 2'd0);
        send_command(FN_CREATE, 2'd0);
        send_command(FN_YIELD, 2'd3);
        send_command(FN_RSVD_LO, 2'd1);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 28)
                f = FN_CREATE;
            else if (k < 53)
                f = FN_YIELD;
            else if (k < 73)
                f = FN_EXIT;
            else if (k < 88)
                f = FN_SETPRI;
            else if (k < 94)
                f = FN_START;
            else
                f = 3'($urandom_range(FN_RSVD_LO, FN_RSVD_HI));
            if (f == FN_EXIT && tracker.exit_halts())
                f = FN_CREATE;
            send_command(f, 2'($urandom_range(0, 3)));
        end

        while (!tracker.halted)
            send_command(FN_EXIT, 2'($urandom_range(0, 3)));
        for (int i = 0; i < 8; i++)
            send_command(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        cmd_ch.valid <= 1'b0;

        while (tracker.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tps_pkg.sv
src/tps_if.sv
src/tps_rdyq.sv
src/three_level_priority_thread_scheduler.sv
tb/three_level_priority_thread_scheduler_tb.sv
